// ===== rtl/binary_to_decimal_ascii_defines.svh =====
// assertion macros shared by the binary to decimal ascii modules
`ifndef BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

// property that must hold at every edge out of reset
`define B2DA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define B2DA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define B2DA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/b2da_pkg.sv =====
// shared types, constants and the place weight table
`timescale 1ns / 1ps
package b2da_pkg;

  localparam int unsigned VALUE_W = 16;
  localparam int unsigned CHAR_W  = 6;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned PLACE_W = 2;
  localparam int unsigned WEIGHT_W = 14;

  localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;
  localparam logic [CHAR_W-1:0]  ASCII_NINE = 6'd57;
  localparam logic [PLACE_W-1:0] PLACE_TENS = 2'd3;

  typedef struct packed {
    logic load;        // take a new value, clear digit and place
    logic sub;         // subtract current weight, bump digit
    logic adv;         // clear digit, move to next place
    logic emit_digit;  // put current digit in the output register
    logic emit_unit;   // put units digit with last set
  } b2da_cmd_t;

  typedef struct packed {
    logic ge;          // rest >= current weight
    logic digit_nz;
    logic started;
    logic place_last;  // current place is tens
    logic out_free;    // output register can take a character
  } b2da_sta_t;

  function automatic logic [WEIGHT_W-1:0] place_weight(input logic [PLACE_W-1:0] place);
    logic [WEIGHT_W-1:0] w;
    case (place)
      2'd0: w = 14'd10000;
      2'd1: w = 14'd1000;
      2'd2: w = 14'd100;
      2'd3: w = 14'd10;
      default: w = 14'd10;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/b2da_datapath.sv =====
// datapath: remainder, digit counter, place index and output register
`timescale 1ns / 1ps
`include "binary_to_decimal_ascii_defines.svh"
module b2da_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [b2da_pkg::VALUE_W-1:0] value,
  input  b2da_pkg::b2da_cmd_t          cmd,
  output b2da_pkg::b2da_sta_t          sta,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [b2da_pkg::CHAR_W-1:0]  character,
  output logic                         last
);
  import b2da_pkg::*;

  logic [VALUE_W-1:0]  rest;
  logic [DIGIT_W-1:0]  digit;
  logic [PLACE_W-1:0]  place;
  logic                started;
  logic [VALUE_W-1:0]  weight;

  assign weight = {{(VALUE_W-WEIGHT_W){1'b0}}, place_weight(place)};

  assign sta.ge         = rest >= weight;
  assign sta.digit_nz   = digit != '0;
  assign sta.started    = started;
  assign sta.place_last = place == PLACE_TENS;
  assign sta.out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rest  <= '0;
      digit <= '0;
      place <= '0;
    end else if (cmd.load) begin
      rest  <= value;
      digit <= '0;
      place <= '0;
    end else begin
      if (cmd.sub) begin
        rest  <= rest - weight;
        digit <= digit + 1'b1;
      end
      if (cmd.adv) begin
        digit <= '0;
        place <= place + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
    end else if (cmd.load) begin
      started <= 1'b0;
    end else if (cmd.emit_digit) begin
      started <= 1'b1;
    end
  end

  // output register, refilled in the cycle the old character leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_digit || cmd.emit_unit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_digit) begin
      character <= ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digit};
      last      <= 1'b0;
    end else if (cmd.emit_unit) begin
      character <= ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, rest[DIGIT_W-1:0]};
      last      <= 1'b1;
    end
  end

  `B2DA_ASSERT(a_digit_range, digit <= 4'd9, "digit counter passed nine")
  `B2DA_ASSERT_IMP(a_char_range, out_valid, character >= ASCII_ZERO && character <= ASCII_NINE, "output character is not a decimal digit")
  `B2DA_ASSERT_NXT(a_unit_last, cmd.emit_unit, out_valid && last, "units digit not flagged last")

endmodule

// ===== rtl/b2da_ctrl.sv =====
// controller state machine sequencing subtract, emit and units steps
`timescale 1ns / 1ps
`include "binary_to_decimal_ascii_defines.svh"
module b2da_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  b2da_pkg::b2da_sta_t sta,
  output b2da_pkg::b2da_cmd_t cmd
);
  import b2da_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SUB  = 2'd1;
  localparam logic [1:0] ST_PUT  = 2'd2;
  localparam logic [1:0] ST_UNIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       want;

  assign in_stall = state != ST_IDLE;
  assign want     = sta.digit_nz || sta.started;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SUB;
        end
      end
      ST_SUB: begin
        if (sta.ge) begin
          cmd.sub = 1'b1;
        end else begin
          state_next = ST_PUT;
        end
      end
      ST_PUT: begin
        // leading zeros are skipped without waiting on the output
        if (!want || sta.out_free) begin
          cmd.emit_digit = want;
          cmd.adv        = 1'b1;
          state_next     = sta.place_last ? ST_UNIT : ST_SUB;
        end
      end
      ST_UNIT: begin
        if (sta.out_free) begin
          cmd.emit_unit = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `B2DA_ASSERT_IMP(a_emit_free, cmd.emit_digit || cmd.emit_unit, sta.out_free, "emit into a full output register")
  `B2DA_ASSERT_IMP(a_sub_ge, cmd.sub, sta.ge && state == ST_SUB, "subtract below weight")
  `B2DA_ASSERT_NXT(a_unit_done, state == ST_UNIT && sta.out_free, state == ST_IDLE, "units step did not finish the item")

endmodule

// ===== rtl/binary_to_decimal_ascii.sv =====
// Top level of the 16-bit unsigned binary to decimal ASCII converter.
// Input channel: value with in_valid / in_stall; a value is taken when
// in_valid is high and in_stall is low, and in_stall stays high until
// the units character of that value has entered the output register.
// Output channel: character and last with out_valid / out_stall; each
// value gives one to five ASCII digits, most significant first, leading
// zeros dropped, last set on the units digit (zero gives a single '0').
// Each place is found by subtracting its weight once per cycle; the
// characters are written while the later places are still converted.
// Holding out_stall keeps the current character in place and pauses the
// conversion at its next character; nothing is lost.
// Reset (rst, synchronous) empties the output register and returns the
// controller to idle.
`timescale 1ns / 1ps
module binary_to_decimal_ascii (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [b2da_pkg::VALUE_W-1:0] value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [b2da_pkg::CHAR_W-1:0]  character,
  output logic                         last
);
  import b2da_pkg::*;

  b2da_cmd_t cmd;
  b2da_sta_t sta;

  b2da_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sta      (sta),
    .cmd      (cmd)
  );

  b2da_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .cmd       (cmd),
    .sta       (sta),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .character (character),
    .last      (last)
  );

endmodule

// ===== sim/b2da_digit_checker.sv =====
// checker that predicts the decimal digits of each value and compares them on the output
`timescale 1ns / 1ps
module b2da_digit_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [b2da_pkg::VALUE_W-1:0] value,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [b2da_pkg::CHAR_W-1:0]  character,
  input  logic                         last,
  output int                           mismatches,
  output int                           digits_due
);
  import b2da_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } ascii_digit_t;

  localparam logic [VALUE_W-1:0] PLACE_WEIGHTS [4] = '{16'd10000, 16'd1000, 16'd100, 16'd10};

  ascii_digit_t expected_digits [$];

  function automatic ascii_digit_t make_digit(input logic [3:0] digit, input logic is_last);
    ascii_digit_t d;
    d.character = ASCII_ZERO + CHAR_W'(digit);
    d.last      = is_last;
    return d;
  endfunction

  // repeated subtraction per place, leading zeros dropped, units always sent
  function automatic void queue_decimal_digits(input logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] rest;
    logic [3:0]         digit;
    logic               started;
    rest    = v;
    started = 1'b0;
    for (int p = 0; p < 4; p++) begin
      digit = '0;
      while (rest >= PLACE_WEIGHTS[p]) begin
        rest  = rest - PLACE_WEIGHTS[p];
        digit = digit + 4'd1;
      end
      if (digit != 0 || started) begin
        expected_digits.push_back(make_digit(digit, 1'b0));
        started = 1'b1;
      end
    end
    expected_digits.push_back(make_digit(rest[3:0], 1'b1));
  endfunction

  always @(posedge clk) begin
    ascii_digit_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        queue_decimal_digits(value);
      end
      if (out_valid && !out_stall) begin
        if (expected_digits.size() == 0) begin
          $error("unexpected item: character %0d last %0b", character, last);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_digits.pop_front();
          if (character !== want.character || last !== want.last) begin
            if (character !== want.character) begin
              $error("character: expected %0d, got %0d", want.character, character);
            end
            if (last !== want.last) begin
              $error("last: expected %0b, got %0b", want.last, last);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
    end
    digits_due <= expected_digits.size();
  end

endmodule

// ===== sim/tb_binary_to_decimal_ascii.sv =====
// testbench top: drives values into the converter and reports the verdict
`timescale 1ns / 1ps
module tb_binary_to_decimal_ascii;
  import b2da_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_VALUES = 140;
  localparam int CALM_TAIL     = 30;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [VALUE_W-1:0] value;
  logic               out_valid;
  logic               out_stall;
  logic [CHAR_W-1:0]  character;
  logic               last;

  int   mismatches;
  int   digits_due;
  int   cycle_count = 0;
  logic bursty;
  logic calm;

  always #2 clk = ~clk;

  binary_to_decimal_ascii u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .character (character),
    .last      (last)
  );

  b2da_digit_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .character  (character),
    .last       (last),
    .mismatches (mismatches),
    .digits_due (digits_due)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[binary_to_decimal_ascii] ERROR");
      $finish;
    end
  end

  // receiver stalls in random bursts
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && bursty && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_value(input logic [VALUE_W-1:0] v);
    if (!calm && bursty && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [VALUE_W-1:0] random_value();
    int pow;
    case ($urandom_range(0, 4))
      0: return VALUE_W'($urandom);
      1: return VALUE_W'($urandom_range(0, 99));
      2: return VALUE_W'($urandom_range(0, 9999));
      3: begin
        // around a power of ten, where the digit count changes
        pow = 10 ** $urandom_range(1, 4);
        return VALUE_W'(pow + $urandom_range(0, 2) - 1);
      end
      default: return VALUE_W'($urandom_range(60000, 65535));
    endcase
  endfunction

  initial begin
    static logic [VALUE_W-1:0] directed [] = '{
      16'd0, 16'd1, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999, 16'd1000,
      16'd9999, 16'd10000, 16'd10001, 16'd10100, 16'd1001, 16'd505, 16'd50,
      16'd59999, 16'd65534, 16'd65535, 16'h5555, 16'hAAAA, 16'h8000, 16'h7FFF
    };
    rst      <= 1'b1;
    in_valid <= 1'b0;
    value    <= '0;
    bursty   <= 1'b1;
    calm     <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_value(directed[i]);

    for (int i = 0; i < RANDOM_VALUES; i++) begin
      if (i % 16 == 0) bursty <= ($urandom_range(0, 3) != 0);
      if (i == RANDOM_VALUES - CALM_TAIL) calm <= 1'b1;
      if (i == RANDOM_VALUES / 2) begin
        // hold off until the converter has drained completely
        in_valid <= 1'b0;
        @(posedge clk);
        while (digits_due != 0) @(posedge clk);
      end
      send_value(random_value());
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (digits_due != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    if (mismatches == 0 && digits_due == 0) begin
      $display("[binary_to_decimal_ascii] OK");
    end else begin
      $display("[binary_to_decimal_ascii] ERROR");
    end
    $finish;
  end

endmodule
